// File: src/ppd_pkg.sv
package ppd_pkg;

  // fixed-point and scheduling constants
  localparam int FIXED_SHIFT        = 11;
  localparam int TICKS_PER_SECOND   = 100;
  localparam int NICE_BIAS          = 20;
  localparam int USER_BASE_PRIORITY = 50;
  localparam int FSCALE             = 1 << FIXED_SHIFT;
  localparam int RSS_PENALTY        = 2 * 4;

  // field widths
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 7;
  localparam int TICK_W   = 8;
  localparam int PCT_W    = 12;
  localparam int USAGE_W  = 8;
  localparam int NICE_W   = 6;
  localparam int PRI_W    = 7;
  localparam int LOAD_W   = 16;
  localparam int DECAY_W  = 12;
  localparam int LMUL_W   = 4;
  localparam int FNICE_W  = 6;
  localparam int PAGE_W   = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // tick share: ticks * FSCALE / TICKS_PER_SECOND by reciprocal multiply
  localparam int RECIP_XS = 16;
  localparam int RECIP_W  = FIXED_SHIFT + 11;
  localparam logic [RECIP_W-1:0] TICK_RECIP = RECIP_W'(
      ((64'd1 << (FIXED_SHIFT + RECIP_XS)) + 64'(TICKS_PER_SECOND) - 64'd1)
      / 64'(TICKS_PER_SECOND));
  localparam int TPROD_W = TICK_W + RECIP_W;
  localparam int SHARE_W = FIXED_SHIFT + 3;

  // cpu percent decay datapath
  localparam int DF_W  = FIXED_SHIFT + 1;
  localparam int SUM_W = 2 * FIXED_SHIFT + 5;
  localparam int SHR_W = SUM_W - FIXED_SHIFT;
  localparam logic [PCT_W-1:0] PCT_CAP = (FSCALE < 4095) ? PCT_W'(FSCALE) : PCT_W'(4095);

  // usage divider
  localparam int B_W   = LOAD_W + LMUL_W;
  localparam int DVS_W = B_W + 1;
  localparam int NUM_W = B_W + USAGE_W;
  localparam int Q_W   = USAGE_W;

  // priority arithmetic
  localparam int A_W = 11;
  localparam int P_W = 12;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // process status codes
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SLEEP  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RUN    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZOMBIE = 3'd5;
  localparam logic [STATUS_W-1:0] ST_STOP   = 3'd6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_AVG  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_MUL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAV_NICE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FREE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DESIRED   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_PRI   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NO_RUN    = 3'd7;

  // register reset values
  localparam logic [DECAY_W-1:0]        RST_DECAY    = 12'd1948;
  localparam logic [LMUL_W-1:0]         RST_LOAD_MUL = 4'd2;
  localparam logic signed [FNICE_W-1:0] RST_FAV_NICE = -6'sd10;
  localparam logic [PRI_W-1:0]          RST_RUN_PRI  = 7'd127;

  typedef struct packed {
    logic [LOAD_W-1:0]         load_average;
    logic [DECAY_W-1:0]        decay_factor;
    logic [LMUL_W-1:0]         load_multiplier;
    logic signed [FNICE_W-1:0] favored_nice;
    logic [PAGE_W-1:0]         free_pages;
    logic [PAGE_W-1:0]         desired_free_pages;
    logic [PRI_W-1:0]          running_priority;
    logic                      no_process_running;
  } ppd_cfg_t;

  // per-request fields that ride along the pipeline
  typedef struct packed {
    logic               active;
    logic               runnable;
    logic [CNT_W-1:0]   tic;
    logic [CNT_W-1:0]   slp;
    logic [PCT_W-1:0]   pct;
    logic [USAGE_W-1:0] usage;
    logic [NICE_W-1:0]  nice;
    logic               loaded;
    logic               favored;
    logic               rss_pen;
    logic [PRI_W-1:0]   spri;
    logic               current;
  } ppd_side_t;

endpackage

// File: src/ppd_front.sv
module ppd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_vld,
  input  logic [ppd_pkg::STATUS_W-1:0]  proc_status,
  input  logic [ppd_pkg::CNT_W-1:0]     time_in_core,
  input  logic [ppd_pkg::CNT_W-1:0]     sleep_seconds,
  input  logic [ppd_pkg::TICK_W-1:0]    cpu_ticks,
  input  logic [ppd_pkg::PCT_W-1:0]     cpu_percent,
  input  logic [ppd_pkg::USAGE_W-1:0]   cpu_usage,
  input  logic [ppd_pkg::NICE_W-1:0]    nice_value,
  input  logic                          is_loaded,
  input  logic                          is_favored,
  input  logic                          over_rss_limit,
  input  logic [ppd_pkg::PRI_W-1:0]     sched_priority,
  input  logic                          is_current,
  input  ppd_pkg::ppd_cfg_t             cfg,
  output logic                          out_vld,
  output ppd_pkg::ppd_side_t            out_side,
  output logic [ppd_pkg::NUM_W-1:0]     out_num,
  output logic [ppd_pkg::DVS_W-1:0]     out_dvs
);
  import ppd_pkg::*;

  logic                 act_c;
  logic                 sleepy_c;
  logic [DF_W-1:0]      dfac_c;
  logic [TPROD_W-1:0]   tprod_c;
  ppd_side_t            s1_side_nxt;

  logic                 s1_vld_r;
  ppd_side_t            s1_side_r;
  logic [B_W-1:0]       b1_r;
  logic [SUM_W-1:0]     dpct1_r;
  logic [SHARE_W-1:0]   share1_r;
  logic [DF_W-1:0]      dcomp1_r;

  logic                 s2_vld_r;
  ppd_side_t            s2_side_r;
  logic [NUM_W-1:0]     num2_r;
  logic [DVS_W-1:0]     dvs2_r;
  logic [SUM_W-1:0]     dpct2_r;
  logic [SUM_W-1:0]     tail2_r;

  logic [SUM_W-1:0]     sum_c;
  logic [SHR_W-1:0]     shr_c;
  logic [PCT_W-1:0]     pctn_c;
  ppd_side_t            s3_side_nxt;

  logic                 s3_vld_r;
  ppd_side_t            s3_side_r;
  logic [NUM_W-1:0]     num3_r;
  logic [DVS_W-1:0]     dvs3_r;

  // stage 1: counters, flags and first products
  always_comb begin
    act_c    = (proc_status != ST_EMPTY) && (proc_status != ST_ZOMBIE);
    sleepy_c = (proc_status == ST_SLEEP) || (proc_status == ST_STOP);
    dfac_c   = (32'(cfg.decay_factor) > 32'(FSCALE)) ? DF_W'(FSCALE)
                                                     : DF_W'(cfg.decay_factor);
    tprod_c  = TPROD_W'(cpu_ticks) * TPROD_W'(TICK_RECIP);

    s1_side_nxt.active   = act_c;
    s1_side_nxt.runnable = proc_status == ST_RUN;
    s1_side_nxt.tic      = (act_c && time_in_core != CNT_MAX) ?
                           time_in_core + CNT_W'(1) : time_in_core;
    s1_side_nxt.slp      = (act_c && sleepy_c && sleep_seconds != CNT_MAX) ?
                           sleep_seconds + CNT_W'(1) : sleep_seconds;
    s1_side_nxt.pct      = cpu_percent;
    s1_side_nxt.usage    = cpu_usage;
    s1_side_nxt.nice     = nice_value;
    s1_side_nxt.loaded   = is_loaded;
    s1_side_nxt.favored  = is_favored;
    s1_side_nxt.rss_pen  = over_rss_limit && (cfg.free_pages < cfg.desired_free_pages);
    s1_side_nxt.spri     = sched_priority;
    s1_side_nxt.current  = is_current;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r <= s1_side_nxt;
      b1_r      <= B_W'(cfg.load_average) * B_W'(cfg.load_multiplier);
      dpct1_r   <= SUM_W'(dfac_c) * SUM_W'(cpu_percent);
      share1_r  <= tprod_c[RECIP_XS +: SHARE_W];
      dcomp1_r  <= DF_W'(FSCALE) - dfac_c;
    end
  end

  // stage 2: dividend, divisor and the tick-share term
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side_r <= s1_side_r;
      num2_r    <= NUM_W'(s1_side_r.usage) * NUM_W'(b1_r);
      dvs2_r    <= DVS_W'(b1_r) + DVS_W'(FSCALE);
      dpct2_r   <= dpct1_r;
      tail2_r   <= SUM_W'(dcomp1_r) * SUM_W'(share1_r);
    end
  end

  // stage 3: finish the cpu percent average and saturate it
  always_comb begin
    sum_c  = dpct2_r + tail2_r;
    shr_c  = sum_c[SUM_W-1:FIXED_SHIFT];
    pctn_c = (shr_c > SHR_W'(PCT_CAP)) ? PCT_CAP : PCT_W'(shr_c);
    s3_side_nxt     = s2_side_r;
    s3_side_nxt.pct = (s2_side_r.active && s2_side_r.loaded) ? pctn_c : s2_side_r.pct;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side_r <= s3_side_nxt;
      num3_r    <= num2_r;
      dvs3_r    <= dvs2_r;
    end
  end

  assign out_vld  = s3_vld_r;
  assign out_side = s3_side_r;
  assign out_num  = num3_r;
  assign out_dvs  = dvs3_r;

endmodule

// File: src/ppd_div.sv
module ppd_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_vld,
  input  ppd_pkg::ppd_side_t         in_side,
  input  logic [ppd_pkg::NUM_W-1:0]  in_num,
  input  logic [ppd_pkg::DVS_W-1:0]  in_dvs,
  output logic                       out_vld,
  output ppd_pkg::ppd_side_t         out_side,
  output logic [ppd_pkg::Q_W-1:0]    out_quo
);
  import ppd_pkg::*;

  // one quotient bit per stage, most significant first
  logic             vld_r  [Q_W];
  ppd_side_t        side_r [Q_W];
  logic [Q_W-1:0]   quo_r  [Q_W];
  logic [NUM_W-1:0] rem_r  [Q_W-1];
  logic [DVS_W-1:0] dvs_r  [Q_W-1];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    localparam int BIT = Q_W - 1 - k;

    logic             vld_i;
    ppd_side_t        side_i;
    logic [NUM_W-1:0] rem_i;
    logic [DVS_W-1:0] dvs_i;
    logic [Q_W-1:0]   quo_i;
    logic [NUM_W-1:0] trial_c;
    logic             take_c;

    if (k == 0) begin : g_head
      assign vld_i  = in_vld;
      assign side_i = in_side;
      assign rem_i  = in_num;
      assign dvs_i  = in_dvs;
      assign quo_i  = '0;
    end else begin : g_link
      assign vld_i  = vld_r[k-1];
      assign side_i = side_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign dvs_i  = dvs_r[k-1];
      assign quo_i  = quo_r[k-1];
    end

    // restoring step against the shifted divisor
    assign trial_c = NUM_W'(dvs_i) << BIT;
    assign take_c  = rem_i >= trial_c;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[k] <= side_i;
        quo_r[k]  <= {quo_i[Q_W-2:0], take_c};
      end
    end

    if (k < Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k] <= take_c ? rem_i - trial_c : rem_i;
          dvs_r[k] <= dvs_i;
        end
      end
    end
  end

  assign out_vld  = vld_r[Q_W-1];
  assign out_side = side_r[Q_W-1];
  assign out_quo  = quo_r[Q_W-1];

endmodule

// File: src/ppd_prio.sv
module ppd_prio (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_vld,
  input  ppd_pkg::ppd_side_t           in_side,
  input  logic [ppd_pkg::Q_W-1:0]      in_quo,
  input  ppd_pkg::ppd_cfg_t            cfg,
  output logic                         out_vld,
  output logic                         out_active,
  output logic [ppd_pkg::CNT_W-1:0]    out_time,
  output logic [ppd_pkg::CNT_W-1:0]    out_sleep,
  output logic [ppd_pkg::PCT_W-1:0]    out_pct,
  output logic [ppd_pkg::USAGE_W-1:0]  out_usage,
  output logic [ppd_pkg::PRI_W-1:0]    out_upri,
  output logic [ppd_pkg::PRI_W-1:0]    out_spri,
  output logic                         out_requeue,
  output logic                         out_resched
);
  import ppd_pkg::*;

  logic signed [A_W-1:0] a_c;
  logic [USAGE_W-1:0]    usage_nxt;

  logic                  p1_vld_r;
  ppd_side_t             p1_side_r;
  logic [USAGE_W-1:0]    usage1_r;

  logic signed [P_W-1:0] p_c;
  logic [P_W-1:0]        fav_c;
  logic [P_W-1:0]        pen_c;
  logic [PRI_W-1:0]      upri_c;
  logic                  band_c;
  logic                  req_c;
  logic                  resched_c;

  logic                  vld_r;
  logic                  active_r;
  logic [CNT_W-1:0]      time_r;
  logic [CNT_W-1:0]      sleep_r;
  logic [PCT_W-1:0]      pct_r;
  logic [USAGE_W-1:0]    usage_r;
  logic [PRI_W-1:0]      upri_r;
  logic [PRI_W-1:0]      spri_r;
  logic                  requeue_r;
  logic                  resched_r;

  // stage 1: add nice to the decayed usage, clamp to 0..255
  always_comb begin
    a_c = A_W'(in_quo) + A_W'(in_side.nice) - A_W'(NICE_BIAS);
    if (a_c[A_W-1]) begin
      usage_nxt = '0;
    end else if (a_c[A_W-2:USAGE_W] != '0) begin
      usage_nxt = {USAGE_W{1'b1}};
    end else begin
      usage_nxt = a_c[USAGE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_side_r <= in_side;
      usage1_r  <= usage_nxt;
    end
  end

  // stage 2: user priority, band move, requeue and reschedule flags
  always_comb begin
    fav_c = p1_side_r.favored ? (P_W'(cfg.favored_nice) << 1) : '0;
    pen_c = p1_side_r.rss_pen ? P_W'(RSS_PENALTY) : '0;
    p_c   = P_W'(usage1_r >> 2) + P_W'(USER_BASE_PRIORITY)
          + ((P_W'(p1_side_r.nice) - P_W'(NICE_BIAS)) << 1) + fav_c + pen_c;
    if (p_c[P_W-1] || p_c == '0) begin
      upri_c = PRI_W'(1);
    end else if (p_c[P_W-2:PRI_W] != '0) begin
      upri_c = {PRI_W{1'b1}};
    end else begin
      upri_c = p_c[PRI_W-1:0];
    end
    band_c    = p1_side_r.spri >= PRI_W'(USER_BASE_PRIORITY);
    req_c     = band_c && (!p1_side_r.current || cfg.no_process_running)
                && p1_side_r.runnable && p1_side_r.loaded && (p1_side_r.spri != upri_c);
    resched_c = upri_c < cfg.running_priority;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      active_r  <= p1_side_r.active;
      time_r    <= p1_side_r.tic;
      sleep_r   <= p1_side_r.slp;
      pct_r     <= p1_side_r.pct;
      usage_r   <= p1_side_r.active ? usage1_r : p1_side_r.usage;
      upri_r    <= p1_side_r.active ? upri_c : '0;
      spri_r    <= (p1_side_r.active && band_c) ? upri_c : p1_side_r.spri;
      requeue_r <= p1_side_r.active && req_c;
      resched_r <= p1_side_r.active && resched_c;
    end
  end

  assign out_vld     = vld_r;
  assign out_active  = active_r;
  assign out_time    = time_r;
  assign out_sleep   = sleep_r;
  assign out_pct     = pct_r;
  assign out_usage   = usage_r;
  assign out_upri    = upri_r;
  assign out_spri    = spri_r;
  assign out_requeue = requeue_r;
  assign out_resched = resched_r;

endmodule

// File: src/process_priority_decay.sv
// channel | dir    | handshake          | payload
// in      | input  | in_valid/in_stall  | one process slot (in_proc_status .. in_is_current)
// out     | output | out_valid/out_stall| recomputed slot (out_active .. out_reschedule)
// cfg     | input  | cfg_valid/cfg_ready| cfg_index, cfg_data (write only)
//
// one request per cycle sustained while the output is not stalled; a result is valid at the output
// after 13 register stages (3 front stages, 8 divider stages at one quotient bit each,
// 2 priority stages, the first loaded at the accepting edge)
// rst_n is synchronous: pipeline valid bits clear, config registers return to defaults
// out_stall with a valid result at the output freezes the whole pipeline and raises in_stall; nothing is dropped
// cfg_ready is always high; writes take effect on the next cycle
module process_priority_decay (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ppd_pkg::STATUS_W-1:0]     in_proc_status,
  input  logic [ppd_pkg::CNT_W-1:0]        in_time_in_core,
  input  logic [ppd_pkg::CNT_W-1:0]        in_sleep_seconds,
  input  logic [ppd_pkg::TICK_W-1:0]       in_cpu_ticks,
  input  logic [ppd_pkg::PCT_W-1:0]        in_cpu_percent,
  input  logic [ppd_pkg::USAGE_W-1:0]      in_cpu_usage,
  input  logic [ppd_pkg::NICE_W-1:0]       in_nice_value,
  input  logic                             in_is_loaded,
  input  logic                             in_is_favored,
  input  logic                             in_over_rss_limit,
  input  logic [ppd_pkg::PRI_W-1:0]        in_sched_priority,
  input  logic                             in_is_current,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_active,
  output logic [ppd_pkg::CNT_W-1:0]        out_new_time_in_core,
  output logic [ppd_pkg::CNT_W-1:0]        out_new_sleep_seconds,
  output logic [ppd_pkg::PCT_W-1:0]        out_new_cpu_percent,
  output logic [ppd_pkg::USAGE_W-1:0]      out_new_cpu_usage,
  output logic [ppd_pkg::PRI_W-1:0]        out_user_priority,
  output logic [ppd_pkg::PRI_W-1:0]        out_new_sched_priority,
  output logic                             out_requeue,
  output logic                             out_reschedule,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ppd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ppd_pkg::*;

  ppd_cfg_t            cfg_r;
  logic                adv;

  logic                fr_vld;
  ppd_side_t           fr_side;
  logic [NUM_W-1:0]    fr_num;
  logic [DVS_W-1:0]    fr_dvs;

  logic                dv_vld;
  ppd_side_t           dv_side;
  logic [Q_W-1:0]      dv_quo;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.load_average       <= '0;
      cfg_r.decay_factor       <= RST_DECAY;
      cfg_r.load_multiplier    <= RST_LOAD_MUL;
      cfg_r.favored_nice       <= RST_FAV_NICE;
      cfg_r.free_pages         <= '0;
      cfg_r.desired_free_pages <= '0;
      cfg_r.running_priority   <= RST_RUN_PRI;
      cfg_r.no_process_running <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOAD_AVG: cfg_r.load_average       <= cfg_data[LOAD_W-1:0];
        REG_DECAY:    cfg_r.decay_factor       <= cfg_data[DECAY_W-1:0];
        REG_LOAD_MUL: cfg_r.load_multiplier    <= cfg_data[LMUL_W-1:0];
        REG_FAV_NICE: cfg_r.favored_nice       <= $signed(cfg_data[FNICE_W-1:0]);
        REG_FREE:     cfg_r.free_pages         <= cfg_data[PAGE_W-1:0];
        REG_DESIRED:  cfg_r.desired_free_pages <= cfg_data[PAGE_W-1:0];
        REG_RUN_PRI:  cfg_r.running_priority   <= cfg_data[PRI_W-1:0];
        REG_NO_RUN:   cfg_r.no_process_running <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // whole pipeline moves unless a finished result is held at the output
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  ppd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_vld         (in_valid),
    .proc_status    (in_proc_status),
    .time_in_core   (in_time_in_core),
    .sleep_seconds  (in_sleep_seconds),
    .cpu_ticks      (in_cpu_ticks),
    .cpu_percent    (in_cpu_percent),
    .cpu_usage      (in_cpu_usage),
    .nice_value     (in_nice_value),
    .is_loaded      (in_is_loaded),
    .is_favored     (in_is_favored),
    .over_rss_limit (in_over_rss_limit),
    .sched_priority (in_sched_priority),
    .is_current     (in_is_current),
    .cfg            (cfg_r),
    .out_vld        (fr_vld),
    .out_side       (fr_side),
    .out_num        (fr_num),
    .out_dvs        (fr_dvs)
  );

  ppd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (fr_vld),
    .in_side  (fr_side),
    .in_num   (fr_num),
    .in_dvs   (fr_dvs),
    .out_vld  (dv_vld),
    .out_side (dv_side),
    .out_quo  (dv_quo)
  );

  ppd_prio u_prio (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_vld      (dv_vld),
    .in_side     (dv_side),
    .in_quo      (dv_quo),
    .cfg         (cfg_r),
    .out_vld     (out_valid),
    .out_active  (out_active),
    .out_time    (out_new_time_in_core),
    .out_sleep   (out_new_sleep_seconds),
    .out_pct     (out_new_cpu_percent),
    .out_usage   (out_new_cpu_usage),
    .out_upri    (out_user_priority),
    .out_spri    (out_new_sched_priority),
    .out_requeue (out_requeue),
    .out_resched (out_reschedule)
  );

endmodule

// File: src/ppd_check.sv
module ppd_check (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_active,
  input logic [ppd_pkg::PRI_W-1:0]     out_user_priority,
  input logic [ppd_pkg::PRI_W-1:0]     out_new_sched_priority,
  input logic                          out_requeue,
  input logic                          out_reschedule
);

  // held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_user_priority)
                               && $stable(out_active) && $stable(out_requeue))
    else $error("stalled result changed");

  // a stalled output must push back on the input side
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output stalled");

  // inactive slots carry no priority and no flags
  a_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_active |-> out_user_priority == '0 && !out_requeue && !out_reschedule)
    else $error("inactive slot with priority or flags");

  // active slots never get priority zero
  a_upri_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_active |-> out_user_priority != '0)
    else $error("active slot with zero user priority");

  // a requeue only happens after moving onto the user priority
  a_requeue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_requeue |-> out_active && out_new_sched_priority == out_user_priority)
    else $error("requeue without priority move");

endmodule

bind process_priority_decay ppd_check u_ppd_check (.*);
